// File: sv/rrt_pkg.sv
// Package for the rule text tokenizer: character codes, phase and kind codes,
// the parser state record and the escape helpers. No dependencies.
package rrt_pkg;

    localparam int CHAR_W = 16;
    localparam int LINE_W = 16;

    localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_SP    = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_HASH  = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 16'h003B;
    localparam logic [CHAR_W-1:0] CH_EQ    = 16'h003D;
    localparam logic [CHAR_W-1:0] CH_BSL   = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_LC_N  = 16'h006E;
    localparam logic [CHAR_W-1:0] CH_LC_S  = 16'h0073;

    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    typedef enum logic [3:0] {
        PH_HEAD       = 4'b0001,
        PH_EQUALS     = 4'b0010,
        PH_TAIL_START = 4'b0100,
        PH_TAIL       = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_HEAD   = 3'd1,
        K_TAIL   = 3'd2,
        K_END    = 3'd3,
        K_EQ_ERR = 3'd4
    } kind_t;

    typedef struct packed {
        phase_t             phase;
        logic               in_comment;
        logic               escape_pending;
        logic               head_seen;
        logic               halted;
        logic [LINE_W-1:0]  line_count;
    } rrt_state_t;

    typedef struct packed {
        kind_t              kind;
        logic               escape_error;
        logic [CHAR_W-1:0]  out_char;
        logic [LINE_W-1:0]  line_number;
    } rrt_result_t;

    localparam rrt_state_t STATE_RESET = '{
        phase:          PH_HEAD,
        in_comment:     1'b0,
        escape_pending: 1'b0,
        head_seen:      1'b0,
        halted:         1'b0,
        line_count:     '0
    };

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c inside {CH_SP, CH_LF, CH_CR, CH_TAB};
    endfunction

    function automatic logic [CHAR_W-1:0] unescape_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        case (c)
            CH_LC_N: r = CH_LF;
            CH_LC_S: r = CH_SP;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic escape_bad(input logic [CHAR_W-1:0] c);
        return !(c inside {CH_LC_N, CH_LC_S, CH_EQ, CH_BSL});
    endfunction

endpackage

// File: sv/rrt_char_if.sv
// Input channel of the rule text tokenizer: one character word per handshake.
// Depends on rrt_pkg.
interface rrt_char_if
    import rrt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              restart;

    modport source (output valid, output char_code, output restart, input ready);
    modport sink   (input valid, input char_code, input restart, output ready);
endinterface

// File: sv/rrt_token_if.sv
// Output channel of the rule text tokenizer: one tagged character word per
// handshake. Depends on rrt_pkg.
interface rrt_token_if
    import rrt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic              escape_error;
    logic [CHAR_W-1:0] out_char;
    logic [LINE_W-1:0] line_number;

    modport source (output valid, output kind, output escape_error, output out_char,
                    output line_number, input ready);
    modport sink   (input valid, input kind, input escape_error, input out_char,
                    input line_number, output ready);
endinterface

// File: sv/rrt_step.sv
// Next-state and result logic for one character of rule text.
// Depends on rrt_pkg.
module rrt_step
    import rrt_pkg::*;
(
    input  rrt_state_t        cur,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              restart,
    output rrt_state_t        nxt,
    output rrt_result_t       res
);

    rrt_state_t        st;
    kind_t             kind;
    logic              err;
    logic [CHAR_W-1:0] ch;

    always_comb
    begin
        st   = restart ? STATE_RESET : cur;
        nxt  = st;
        kind = K_NONE;
        err  = 1'b0;
        ch   = '0;

        if (!st.halted)
        begin
            if (char_code == CH_LF && st.line_count != LINE_MAX)
                nxt.line_count = st.line_count + LINE_W'(1);

            if (st.in_comment)
            begin
                if (char_code == CH_LF)
                    nxt.in_comment = 1'b0;
            end
            else if (char_code == CH_HASH)
            begin
                // keep any pending escape across the comment
                nxt.in_comment = 1'b1;
            end
            else
            begin
                case (st.phase)
                    PH_HEAD:
                    begin
                        if (st.escape_pending)
                        begin
                            ch                 = unescape_char(char_code);
                            err                = escape_bad(char_code);
                            kind               = K_HEAD;
                            nxt.head_seen      = 1'b1;
                            nxt.escape_pending = 1'b0;
                        end
                        else if (is_space(char_code))
                        begin
                            if (st.head_seen)
                                nxt.phase = PH_EQUALS;
                        end
                        else if (char_code == CH_BSL)
                            nxt.escape_pending = 1'b1;
                        else if (char_code == CH_EQ)
                            nxt.phase = PH_TAIL_START;
                        else
                        begin
                            ch            = char_code;
                            kind          = K_HEAD;
                            nxt.head_seen = 1'b1;
                        end
                    end
                    PH_EQUALS:
                    begin
                        if (!is_space(char_code))
                        begin
                            if (char_code == CH_EQ)
                                nxt.phase = PH_TAIL_START;
                            else
                            begin
                                kind       = K_EQ_ERR;
                                nxt.halted = 1'b1;
                            end
                        end
                    end
                    PH_TAIL_START:
                    begin
                        if (st.escape_pending)
                        begin
                            ch                 = unescape_char(char_code);
                            err                = escape_bad(char_code);
                            kind               = K_TAIL;
                            nxt.escape_pending = 1'b0;
                            nxt.phase          = PH_TAIL;
                        end
                        else if (is_space(char_code))
                        begin
                            // drop leading tail whitespace
                        end
                        else if (char_code == CH_BSL)
                            nxt.escape_pending = 1'b1;
                        else
                        begin
                            ch        = char_code;
                            kind      = K_TAIL;
                            nxt.phase = PH_TAIL;
                        end
                    end
                    default:
                    begin
                        if (st.escape_pending)
                        begin
                            ch                 = unescape_char(char_code);
                            err                = escape_bad(char_code);
                            kind               = K_TAIL;
                            nxt.escape_pending = 1'b0;
                        end
                        else if (char_code == CH_BSL)
                            nxt.escape_pending = 1'b1;
                        else if (char_code == CH_SEMI)
                        begin
                            kind          = K_END;
                            nxt.phase     = PH_HEAD;
                            nxt.head_seen = 1'b0;
                        end
                        else
                        begin
                            ch   = char_code;
                            kind = K_TAIL;
                        end
                    end
                endcase
            end
        end

        res.kind         = kind;
        res.escape_error = err;
        res.out_char     = ch;
        res.line_number  = nxt.line_count;
    end

endmodule

// File: sv/rewrite_rule_text_tokenizer.sv
// Top level of the rule text tokenizer: parser state register, result register
// and handshake. Depends on rrt_pkg, rrt_char_if, rrt_token_if and rrt_step.
//
//   channel   dir   word                                         per word
//   chars     in    char_code[15:0], restart                     one character
//   tokens    out   kind[2:0], escape_error, out_char[15:0],     one tag
//                   line_number[15:0]
//
// One character a cycle while chars.ready is high: each accepted word is decoded
// against the state register in the same cycle and its tag lands in the result
// register; tokens.valid rises in the cycle after acceptance.
// Reset puts the parser in the head phase with line count zero; restart does the
// same ahead of its own character.
// A stalled result holds; chars.ready stays high while the result is being taken.
module rewrite_rule_text_tokenizer
    import rrt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rrt_char_if.sink      chars,
    rrt_token_if.source   tokens
);

    rrt_state_t  state_reg;
    rrt_state_t  state_next;
    rrt_result_t res_reg;
    rrt_result_t res_next;
    logic        out_valid_reg;
    logic        accept;

    rrt_step u_step (
        .cur       (state_reg),
        .char_code (chars.char_code),
        .restart   (chars.restart),
        .nxt       (state_next),
        .res       (res_next)
    );

    assign chars.ready = !out_valid_reg || tokens.ready;
    assign accept      = chars.valid && chars.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (tokens.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign tokens.valid        = out_valid_reg;
    assign tokens.kind         = res_reg.kind;
    assign tokens.escape_error = res_reg.escape_error;
    assign tokens.out_char     = res_reg.out_char;
    assign tokens.line_number  = res_reg.line_number;

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg.phase))
        else $error("parser phase not one-hot");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && state_reg.halted && !chars.restart |=> tokens.kind == K_NONE)
        else $error("halted tokenizer produced a tag");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_next.kind == K_EQ_ERR |=> state_reg.halted)
        else $error("equals-expected error did not halt");

    a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !chars.restart |=> tokens.line_number >= $past(state_reg.line_count))
        else $error("line count went backwards");

endmodule

// File: tb/tb.sv
// Self-checking bench for rewrite_rule_text_tokenizer: directed and random rule text,
// random stalls on both channels and a running tag predictor.
// Depends on rrt_pkg, rrt_char_if, rrt_token_if and the tokenizer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrt_pkg::*;

    // Slowest legal run is roughly 2.2k characters.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_CHARS = 1800;
    localparam int PRINT_CAP = 40;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              rs;
    } char_word_t;

    typedef struct {
        kind_t             kind;
        logic              esc_err;
        logic [CHAR_W-1:0] ch;
        logic [LINE_W-1:0] line;
    } tag_t;

    logic clk = 1'b0;
    logic rst_n;

    rrt_char_if  chars_if ();
    rrt_token_if tokens_if ();

    rewrite_rule_text_tokenizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    always #5 clk = ~clk;

    char_word_t char_backlog[$];
    tag_t       tags_due[$];

    int mismatches = 0;
    int fed_chars = 0;
    int cycles = 0;
    int tags_by_kind[0:4] = '{default: 0};

    // Predictor state, starts at its reset value
    phase_t            ps_phase = PH_HEAD;
    logic              ps_in_cmt = 1'b0;
    logic              ps_esc = 1'b0;
    logic              ps_head_seen = 1'b0;
    logic              ps_halted = 1'b0;
    logic [LINE_W-1:0] ps_lines = '0;

    function automatic tag_t tokenize_char(input logic [CHAR_W-1:0] c, input logic rs);
        tag_t              t;
        logic              ws;
        logic [CHAR_W-1:0] lit;
        logic              lit_bad;
        t.kind = K_NONE;
        t.esc_err = 1'b0;
        t.ch = '0;
        if (rs) begin
            ps_phase = PH_HEAD;
            ps_in_cmt = 1'b0;
            ps_esc = 1'b0;
            ps_head_seen = 1'b0;
            ps_halted = 1'b0;
            ps_lines = '0;
        end
        ws = (c == CH_SP) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
        lit_bad = 1'b0;
        case (c)
            CH_LC_N:       lit = CH_LF;
            CH_LC_S:       lit = CH_SP;
            CH_EQ, CH_BSL: lit = c;
            default:
            begin
                lit = c;
                lit_bad = 1'b1;
            end
        endcase
        if (!ps_halted) begin
            if (c == CH_LF && ps_lines != LINE_MAX)
                ps_lines = ps_lines + LINE_W'(1);
            if (ps_in_cmt) begin
                if (c == CH_LF)
                    ps_in_cmt = 1'b0;
            end
            else if (c == CH_HASH) begin
                ps_in_cmt = 1'b1;
            end
            else begin
                case (ps_phase)
                    PH_HEAD:
                    begin
                        if (ps_esc) begin
                            t.kind = K_HEAD;
                            t.ch = lit;
                            t.esc_err = lit_bad;
                            ps_head_seen = 1'b1;
                            ps_esc = 1'b0;
                        end
                        else if (ws) begin
                            if (ps_head_seen)
                                ps_phase = PH_EQUALS;
                        end
                        else if (c == CH_BSL) begin
                            ps_esc = 1'b1;
                        end
                        else if (c == CH_EQ) begin
                            ps_phase = PH_TAIL_START;
                        end
                        else begin
                            t.kind = K_HEAD;
                            t.ch = c;
                            ps_head_seen = 1'b1;
                        end
                    end
                    PH_EQUALS:
                    begin
                        if (!ws) begin
                            if (c == CH_EQ) begin
                                ps_phase = PH_TAIL_START;
                            end
                            else begin
                                t.kind = K_EQ_ERR;
                                ps_halted = 1'b1;
                            end
                        end
                    end
                    PH_TAIL_START:
                    begin
                        if (ps_esc) begin
                            t.kind = K_TAIL;
                            t.ch = lit;
                            t.esc_err = lit_bad;
                            ps_esc = 1'b0;
                            ps_phase = PH_TAIL;
                        end
                        else if (ws) begin
                            // skip leading blanks of the tail
                        end
                        else if (c == CH_BSL) begin
                            ps_esc = 1'b1;
                        end
                        else begin
                            t.kind = K_TAIL;
                            t.ch = c;
                            ps_phase = PH_TAIL;
                        end
                    end
                    default:
                    begin
                        if (ps_esc) begin
                            t.kind = K_TAIL;
                            t.ch = lit;
                            t.esc_err = lit_bad;
                            ps_esc = 1'b0;
                        end
                        else if (c == CH_BSL) begin
                            ps_esc = 1'b1;
                        end
                        else if (c == CH_SEMI) begin
                            t.kind = K_END;
                            ps_phase = PH_HEAD;
                            ps_head_seen = 1'b0;
                        end
                        else begin
                            t.kind = K_TAIL;
                            t.ch = c;
                        end
                    end
                endcase
            end
        end
        t.line = ps_lines;
        return t;
    endfunction

    task automatic report(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
        mismatches++;
    endtask

    // Stimulus helpers
    task automatic feed(input logic [CHAR_W-1:0] code, input logic rs = 1'b0,
                        input bit counted = 1'b1);
        char_word_t w;
        w.code = code;
        w.rs = rs;
        char_backlog.push_back(w);
        if (counted)
            fed_chars++;
    endtask

    function automatic logic [CHAR_W-1:0] plain_char();
        int unsigned       p;
        logic [CHAR_W-1:0] c;
        p = $urandom_range(0, 9);
        do begin
            if (p < 6)
                c = CHAR_W'($urandom_range(16'h21, 16'h7E));
            else if (p < 9)
                c = CHAR_W'($urandom_range(16'h80, 16'hFFFF));
            else
                c = CHAR_W'($urandom_range(16'h00, 16'h1F));
        end while (c == CH_HASH || c == CH_SEMI || c == CH_EQ || c == CH_BSL ||
                   c == CH_TAB || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] special_char();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 9))
            0: c = CH_TAB;
            1: c = CH_LF;
            2: c = CH_CR;
            3: c = CH_SP;
            4: c = CH_HASH;
            5: c = CH_SEMI;
            6: c = CH_EQ;
            7: c = CH_BSL;
            8: c = CH_LC_N;
            default: c = CH_LC_S;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] ws_char();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 3))
            0: c = CH_SP;
            1: c = CH_TAB;
            2: c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] any_char();
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] s;
        s = special_char();
        case ($urandom_range(0, 4))
            0: c = s;
            1, 2: c = CHAR_W'($urandom_range(0, 16'hFFFF));
            // special low byte under a non-zero high byte
            3: c = {8'($urandom_range(1, 255)), s[7:0]};
            default: c = plain_char();
        endcase
        return c;
    endfunction

    task automatic feed_escape();
        logic [CHAR_W-1:0] target;
        case ($urandom_range(0, 4))
            0: target = CH_LC_N;
            1: target = CH_LC_S;
            2: target = CH_EQ;
            3: target = CH_BSL;
            default: target = any_char();
        endcase
        feed(CH_BSL);
        // comment in the middle of an escape keeps the escape armed
        if ($urandom_range(0, 7) == 0) begin
            feed(CH_HASH, 1'b0, 1'b0);
            feed(CH_LF, 1'b0, 1'b0);
        end
        feed(target);
    endtask

    task automatic feed_rule();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 4) == 0) begin
            feed(CH_HASH, 1'b0, 1'b0);
            repeat ($urandom_range(0, 4)) begin
                c = any_char();
                feed(c == CH_LF ? CH_HASH : c, 1'b0, 1'b0);
            end
            feed(CH_LF, 1'b0, 1'b0);
        end
        repeat ($urandom_range(0, 1))
            feed(ws_char(), 1'b0, 1'b0);
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 4) == 0)
                feed_escape();
            else
                feed(plain_char());
        end
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 2))
                feed(ws_char());
        feed(CH_EQ);
        repeat ($urandom_range(0, 2))
            feed(ws_char());
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 6))
                0: feed_escape();
                1: feed(ws_char());
                2:
                begin
                    feed(CH_HASH);
                    feed(CH_LF);
                end
                default: feed(plain_char());
            endcase
        end
        feed(CH_SEMI);
        if ($urandom_range(0, 1) == 1)
            feed(CH_LF);
    endtask

    // Head, blank, then anything but '=': halts until a restart
    task automatic feed_broken_rule();
        repeat ($urandom_range(1, 3))
            feed(plain_char());
        feed(ws_char());
        feed(plain_char());
        repeat ($urandom_range(1, 5))
            feed(any_char(), 1'b0, 1'b0);
        feed(any_char(), 1'b1);
    endtask

    task automatic feed_noise();
        repeat ($urandom_range(1, 8))
            feed(any_char(), $urandom_range(0, 29) == 0);
    endtask

    // Sample on the falling edge so the rising-edge updates have all landed
    task automatic settle();
        @(negedge clk);
        while (!(char_backlog.size() == 0 && !chars_if.valid && tags_due.size() == 0))
            @(negedge clk);
    endtask

    // Driver: bursts of random length separated by random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n) begin
        char_word_t w;
        if (!rst_n) begin
            chars_if.valid <= 1'b0;
            chars_if.char_code <= '0;
            chars_if.restart <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else if (!chars_if.valid || chars_if.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                chars_if.valid <= 1'b0;
            end
            else if (char_backlog.size() != 0) begin
                w = char_backlog.pop_front();
                chars_if.valid <= 1'b1;
                chars_if.char_code <= w.code;
                chars_if.restart <= w.rs;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else begin
                chars_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall style is drawn anew whenever rx_span runs out
    int rx_span = 0;
    int rx_mode = 0;
    int rx_hold = 0;

    always @(posedge clk or negedge rst_n) begin
        logic r;
        if (!rst_n) begin
            tokens_if.ready <= 1'b0;
        end
        else begin
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(50, 300);
            end
            rx_span--;
            case (rx_mode)
                0: r = 1'b1;
                1: r = $urandom_range(0, 1);
                2: r = ($urandom_range(0, 9) != 0);
                default:
                begin
                    if (rx_hold == 0)
                        rx_hold = $urandom_range(1, 8);
                    rx_hold--;
                    r = (rx_hold == 0);
                end
            endcase
            tokens_if.ready <= r;
        end
    end

    // Monitor: check the tag word first, then predict from the character word
    always @(posedge clk) begin
        tag_t want;
        if (rst_n) begin
            if (tokens_if.valid && tokens_if.ready) begin
                if (tags_due.size() == 0) begin
                    report("unexpected tag, kind", int'(tokens_if.kind), 0);
                end
                else begin
                    want = tags_due.pop_front();
                    tags_by_kind[int'(want.kind)]++;
                    if (tokens_if.kind !== want.kind)
                        report("kind", int'(tokens_if.kind), int'(want.kind));
                    if (tokens_if.escape_error !== want.esc_err)
                        report("escape_error", int'(tokens_if.escape_error), int'(want.esc_err));
                    if (tokens_if.out_char !== want.ch)
                        report("out_char", int'(tokens_if.out_char), int'(want.ch));
                    if (tokens_if.line_number !== want.line)
                        report("line_number", int'(tokens_if.line_number), int'(want.line));
                end
            end
            if (chars_if.valid && chars_if.ready)
                tags_due.push_back(tokenize_char(chars_if.char_code, chars_if.restart));
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int pick;
        rst_n = 1'b0;
        chars_if.valid = 1'b0;
        chars_if.char_code = '0;
        chars_if.restart = 1'b0;
        tokens_if.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rule text
        feed(16'h0061, 1'b1);
        feed(16'hFFFF);
        feed(16'h0000);
        feed(CH_BSL);
        feed(CH_SP);        // escaped blank: literal, flagged
        feed(CH_TAB);       // blank ends the head
        feed(CH_SP);
        feed(CH_EQ);
        feed(CH_BSL);
        feed(CH_HASH);      // comment opens with the escape still armed
        feed(16'h007A);
        feed(CH_LF);
        feed(CH_LC_N);      // escaped n after the comment
        feed(CH_SP);        // blank inside the tail is a tail character
        feed(CH_BSL);
        feed(CH_BSL);
        feed(CH_BSL);
        feed(CH_SEMI);      // escaped ';' stays literal
        feed(CH_SEMI);
        feed(CH_EQ);        // '=' with an empty head
        feed(CH_BSL);
        feed(CH_LC_S);
        feed(CH_SEMI);
        feed(16'h0068);
        feed(CH_CR);
        feed(16'h0071);     // '=' expected: halt
        feed(CH_LF);        // ignored while halted
        feed(16'h0061, 1'b1);
        settle();

        while (fed_chars < RANDOM_CHARS + 28) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                feed_rule();
            else if (pick < 17)
                feed_broken_rule();
            else
                feed_noise();
        end
        settle();
        repeat (10) @(posedge clk);

        $display("covered: %0d characters, head %0d, tail %0d, rule end %0d, '=' errors %0d",
                 fed_chars, tags_by_kind[1], tags_by_kind[2], tags_by_kind[3], tags_by_kind[4]);
        $display("covered: %0d blank tags, escapes, comments, halt and restart",
                 tags_by_kind[0]);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
